>>> rtl/configurable_crc_byte_engine_defines.svh
// Assertion macros used by the checker file of the CRC byte engine.
`ifndef CONFIGURABLE_CRC_BYTE_ENGINE_DEFINES_SVH
`define CONFIGURABLE_CRC_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRCBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRCBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define CRCBE_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/crcbe_pkg.sv
// Shared types, constants and bit-order helpers of the CRC byte engine.
package crcbe_pkg;

    localparam int CRC_W_MAX       = 64;
    localparam int CRC_W_MIN       = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Reset values of the configuration registers (standard CRC-32)
    localparam logic [6:0]  RST_WIDTH   = 7'd32;
    localparam logic [63:0] RST_POLY    = 64'h0000_0000_04C1_1DB7;
    localparam logic [63:0] RST_START   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] RST_XOR     = 64'h0000_0000_FFFF_FFFF;
    localparam logic        RST_REF_IN  = 1'b1;
    localparam logic        RST_REF_OUT = 1'b1;
    // Alignment shift of the reset width (64 - 32)
    localparam logic [5:0]  RST_SHIFT   = 6'd32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_POLY    = 3'd1,
        REG_START   = 3'd2,
        REG_XOR     = 3'd3,
        REG_REF_IN  = 3'd4,
        REG_REF_OUT = 3'd5
    } t_reg_idx;

    // One queued word: message byte (already in processing bit order) and last mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_qword;

    // Settled configuration, CRC values kept left-aligned (top bit at 63)
    typedef struct packed {
        logic        busy;      // a register write has not settled yet
        logic [5:0]  shift;     // 64 - effective width
        logic [63:0] poly_al;   // polynomial, left-aligned
        logic [63:0] start_al;  // start value, left-aligned
        logic [63:0] xor_m;     // output xor, masked to width
        logic        ref_in;
        logic        ref_out;
    } t_cfg;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [63:0] rev64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) begin
            r[i] = v[63-i];
        end
        return r;
    endfunction

    // Width clamped into 8..64
    function automatic logic [6:0] eff_width(input logic [6:0] w);
        logic [6:0] r;
        if (w < 7'(CRC_W_MIN)) begin
            r = 7'(CRC_W_MIN);
        end else if (w > 7'(CRC_W_MAX)) begin
            r = 7'(CRC_W_MAX);
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

>>> rtl/crcbe_queue.sv
// Small register queue between the front classifier and the CRC back end.
module crcbe_queue
    import crcbe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qword i_wdata,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_qword o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qword             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> rtl/crcbe_front.sv
// Input side: stream handshake, byte reflection and last-byte classification.
module crcbe_front
    import crcbe_pkg::*;
(
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    input  logic       i_cfg_wr_en,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_qword     o_q_wdata
);

    // hold off input while the queue is full or a register write is landing
    assign s_axis_tready = !i_q_full && !i_cfg_wr_en && !i_cfg.busy;
    assign o_q_push      = s_axis_tvalid && s_axis_tready;

    // byte enters the register MSB-first, reversed first when asked
    always_comb begin
        o_q_wdata.data = i_cfg.ref_in ? rev8(s_axis_tdata) : s_axis_tdata;
        o_q_wdata.last = s_axis_tlast;
    end

endmodule

>>> rtl/crcbe_back.sv
// Back end: left-aligned CRC update (eight XOR steps per word) and result output.
module crcbe_back
    import crcbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_qword      i_q_rdata,
    output logic        o_q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] crc_value
);

    logic [63:0] r_crc, n_crc;         // running CRC, left-aligned
    logic [5:0]  r_al_shift;           // alignment the running CRC is held in
    logic        r_in_msg, n_in_msg;
    logic        r_fin_valid, n_fin_valid;
    logic [63:0] r_fin;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out;

    logic        aligned;
    logic        fin_move, fin_acc, out_acc;
    logic [63:0] step_crc;
    logic [63:0] fmt;

    // output register and finish stage flow control
    assign out_acc  = !r_out_valid || m_axis_tready;
    assign fin_move = r_fin_valid && out_acc;
    assign fin_acc  = !r_fin_valid || fin_move;
    assign aligned  = (r_al_shift == i_cfg.shift);

    assign o_q_pop = i_q_valid && !i_cfg.busy && aligned && (!i_q_rdata.last || fin_acc);

    // eight MSB-first shift/XOR steps on the aligned register
    always_comb begin
        logic [63:0] a;
        logic        top;
        a = r_in_msg ? r_crc : i_cfg.start_al;
        for (int i = 7; i >= 0; i--) begin
            top = a[63] ^ i_q_rdata.data[i];
            a   = {a[62:0], 1'b0} ^ (top ? i_cfg.poly_al : 64'd0);
        end
        step_crc = a;
    end

    // finished CRC: reflect over width or bring down to bit 0, then xor
    assign fmt = (i_cfg.ref_out ? rev64(r_fin) : (r_fin >> i_cfg.shift)) ^ i_cfg.xor_m;

    // running state update; a width change realigns the held CRC first
    always_comb begin
        n_crc       = r_crc;
        n_in_msg    = r_in_msg;
        n_fin_valid = r_fin_valid;
        n_out_valid = r_out_valid;
        if (!aligned) begin
            n_crc = (r_crc >> r_al_shift) << i_cfg.shift;
        end else if (o_q_pop) begin
            n_crc    = step_crc;
            n_in_msg = !i_q_rdata.last;
        end
        if (fin_move) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (o_q_pop && i_q_rdata.last) begin
            n_fin_valid = 1'b1;
        end else if (fin_move) begin
            n_fin_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_al_shift  <= RST_SHIFT;
            r_in_msg    <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_al_shift  <= i_cfg.shift;
            r_in_msg    <= n_in_msg;
            r_fin_valid <= n_fin_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (o_q_pop && i_q_rdata.last) begin
            r_fin <= step_crc;
        end
        if (fin_move) begin
            r_out <= fmt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

>>> rtl/configurable_crc_byte_engine.sv
// Configurable CRC byte engine: one message byte per cycle when not held off, any CRC
// of 8 to 64 bits (polynomial, start value, output xor, input and output reflection
// set through the register port). Sustained rate is one byte per clock; the eight
// chained shift/XOR steps of the CRC update in the back end set that figure. A
// message's CRC passes through the finish register to the output register. The
// input holds off during a register write and in the cycle after it, and after a
// width change the back end realigns the running CRC before taking the next byte.
module configurable_crc_byte_engine
    import crcbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last_byte
    // CRC result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [63:0] crc_value
    // register write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_wdata
);

    logic [6:0]  r_width;
    logic [63:0] r_poly, r_start, r_xor;
    logic        r_ref_in, r_ref_out;
    t_cfg        r_cfg, n_cfg;

    logic        q_full, q_push, q_pop, q_valid;
    t_qword      q_wdata, q_rdata;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_poly    <= RST_POLY;
            r_start   <= RST_START;
            r_xor     <= RST_XOR;
            r_ref_in  <= RST_REF_IN;
            r_ref_out <= RST_REF_OUT;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_WIDTH:   r_width   <= i_cfg_wdata[6:0];
                REG_POLY:    r_poly    <= i_cfg_wdata;
                REG_START:   r_start   <= i_cfg_wdata;
                REG_XOR:     r_xor     <= i_cfg_wdata;
                REG_REF_IN:  r_ref_in  <= i_cfg_wdata[0];
                REG_REF_OUT: r_ref_out <= i_cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // derived, left-aligned configuration, registered from the raw registers
    always_comb begin
        logic [6:0] w;
        logic [6:0] sh;
        w              = eff_width(r_width);
        sh             = 7'(CRC_W_MAX) - w;
        n_cfg.busy     = i_cfg_wr_en;
        n_cfg.shift    = sh[5:0];
        n_cfg.poly_al  = r_poly << sh[5:0];
        n_cfg.start_al = r_start << sh[5:0];
        n_cfg.xor_m    = r_xor & ({64{1'b1}} >> sh[5:0]);
        n_cfg.ref_in   = r_ref_in;
        n_cfg.ref_out  = r_ref_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.busy     <= 1'b1;
            r_cfg.shift    <= RST_SHIFT;
            r_cfg.poly_al  <= RST_POLY << RST_SHIFT;
            r_cfg.start_al <= RST_START << RST_SHIFT;
            r_cfg.xor_m    <= RST_XOR;
            r_cfg.ref_in   <= RST_REF_IN;
            r_cfg.ref_out  <= RST_REF_OUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    crcbe_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg         (r_cfg),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_wdata     (q_wdata)
    );

    crcbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    crcbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_rdata     (q_rdata),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/crcbe_checker.sv
// Port-level checks of the CRC byte engine, bound to the top level.
`include "configurable_crc_byte_engine_defines.svh"

module crcbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        i_cfg_wr_en
);

    // input is held off during a register write and the cycle after it
    `CRCBE_ASSERT_NOW(a_no_take_on_write, i_cfg_wr_en, !s_axis_tready, "word taken during register write")
    `CRCBE_ASSERT_NEXT(a_settle_after_write, i_cfg_wr_en, !s_axis_tready, "word taken while register write settles")

    // a result can only follow a last byte; none comes out of reset
    `CRCBE_ASSERT_ALWAYS(a_quiet_after_reset, !i_rst_n, !m_axis_tvalid, "result valid right after reset")

    // stalled result holds
    `CRCBE_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result dropped or changed")

endmodule

bind configurable_crc_byte_engine crcbe_checker u_crcbe_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the configurable CRC byte engine.
`timescale 1ns / 100ps

module tb_top
    import crcbe_pkg::*;
();

    localparam int DRAIN_CYCLES = 8;   // drain margin after the last expected result
    localparam int HOLD_CYCLES  = 300;

    // Expected-CRC scoreboard: its own copy of the settings and of the running CRC
    class crc_scoreboard;
        bit [6:0]  width_reg;
        bit [63:0] poly_reg;
        bit [63:0] start_reg;
        bit [63:0] xor_reg;
        bit        ref_in_reg;
        bit        ref_out_reg;
        bit [63:0] crc_acc;
        bit        mid_msg;
        bit [63:0] crc_expected[$];
        int        errors;

        function new();
            width_reg   = 7'd32;
            poly_reg    = 64'h04C1_1DB7;
            start_reg   = 64'hFFFF_FFFF;
            xor_reg     = 64'hFFFF_FFFF;
            ref_in_reg  = 1'b1;
            ref_out_reg = 1'b1;
            crc_acc     = '0;
            mid_msg     = 1'b0;
            errors      = 0;
        endfunction

        task report_error(input string msg);
            $display("%0t  MISMATCH  %s", $realtime, msg);
            errors++;
        endtask

        function bit [63:0] flip(input bit [63:0] v, input int n);
            bit [63:0] r;
            r = '0;
            for (int i = 0; i < n; i++) begin
                r[n-1-i] = v[i];
            end
            return r;
        endfunction

        function void set_reg(input t_reg_idx idx, input bit [63:0] val);
            case (idx)
                REG_WIDTH:   width_reg   = val[6:0];
                REG_POLY:    poly_reg    = val;
                REG_START:   start_reg   = val;
                REG_XOR:     xor_reg     = val;
                REG_REF_IN:  ref_in_reg  = val[0];
                REG_REF_OUT: ref_out_reg = val[0];
                default: ;
            endcase
        endfunction

        // Accepted input word: advance the CRC, queue a result on the last byte
        function void note_byte(input bit [7:0] data, input bit last);
            int        w;
            bit [63:0] m;
            bit [63:0] crc;
            bit [7:0]  b;
            bit        top;
            w = (width_reg < 7'd8) ? 8 : (width_reg > 7'd64) ? 64 : int'(width_reg);
            m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
            crc = (mid_msg ? crc_acc : start_reg) & m;
            b = ref_in_reg ? 8'(flip(64'(data), 8)) : data;
            for (int i = 0; i < 8; i++) begin
                top = crc[w-1] ^ b[7-i];
                crc = (crc << 1) & m;
                if (top) crc ^= poly_reg & m;
            end
            if (last) begin
                if (ref_out_reg) crc = flip(crc, w);
                crc_expected = {crc_expected, (crc ^ xor_reg) & m};
                crc_acc = start_reg & m;
                mid_msg = 1'b0;
            end else begin
                crc_acc = crc;
                mid_msg = 1'b1;
            end
        endfunction

        task check_crc(input bit [63:0] got);
            bit [63:0] want;
            if (crc_expected.size() == 0) begin
                report_error($sformatf("unexpected crc word %h", got));
            end else begin
                want = crc_expected.pop_front();
                if (got !== want)
                    report_error($sformatf("crc_value got %h want %h", got, want));
            end
        endtask

        function int pending();
            return crc_expected.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [7:0] data_byte
    logic                 s_axis_tlast = 1'b0;  // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;         // [63:0] crc_value
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0]          i_cfg_wdata = '0;

    crc_scoreboard sb = new();

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;

    configurable_crc_byte_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, or a long hold-off when one is requested
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_crc(m_axis_tdata);
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for the handshake
    task automatic send_word(input logic [7:0] data, input logic last);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(data, last);
    endtask

    // Register write; the caller lowers the enable after the last one
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Stop offering, wait for every expected CRC, then let the pipe settle
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic random_settings();
        logic [6:0] w;
        case ($urandom_range(0, 9))
            0: w = 7'd8;
            1: w = 7'd64;
            2: w = 7'($urandom_range(0, 7));
            3: w = 7'($urandom_range(65, 127));
            default: w = 7'($urandom_range(9, 63));
        endcase
        write_reg(REG_WIDTH, 64'(w));
        write_reg(REG_POLY, pick_value());
        write_reg(REG_START, pick_value());
        write_reg(REG_XOR, pick_value());
        write_reg(REG_REF_IN, 64'($urandom_range(0, 1)));
        write_reg(REG_REF_OUT, 64'($urandom_range(0, 1)));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Whole messages of random bytes, mostly short
    task automatic run_messages(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_word(8'($urandom_range(0, 255)), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (CRC-32): check string, single-byte extremes
        for (int i = 0; i < 9; i++) begin
            send_word(8'h31 + 8'(i), i == 8);
        end
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);

        // Settings changed in the middle of a message
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b0);
        quiesce();
        write_reg(REG_WIDTH, 64'd16);
        write_reg(REG_POLY, 64'h1021);
        i_cfg_wr_en <= 1'b0;
        send_word(8'h3C, 1'b1);

        // Width below range acts as 8, no reflection
        quiesce();
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_POLY, 64'h07);
        write_reg(REG_START, 64'h0);
        write_reg(REG_XOR, 64'h0);
        write_reg(REG_REF_IN, 64'd0);
        write_reg(REG_REF_OUT, 64'd0);
        i_cfg_wr_en <= 1'b0;
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b1);

        // Width above range acts as 64, with an all-ones polynomial and start value
        quiesce();
        write_reg(REG_WIDTH, 64'd127);
        write_reg(REG_POLY, '1);
        write_reg(REG_START, '1);
        i_cfg_wr_en <= 1'b0;
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);

        // Full 64-bit width, both reflections, wide values on a short width
        quiesce();
        write_reg(REG_WIDTH, 64'd64);
        write_reg(REG_POLY, 64'h42F0_E1EB_A9EA_3693);
        write_reg(REG_XOR, '1);
        write_reg(REG_REF_IN, 64'd1);
        write_reg(REG_REF_OUT, 64'd1);
        i_cfg_wr_en <= 1'b0;
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);
        quiesce();
        write_reg(REG_WIDTH, 64'd8);
        i_cfg_wr_en <= 1'b0;
        send_word(8'hC3, 1'b1);

        // Random part: two settings per idling mode
        for (int ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            quiesce();
            random_settings();
            // long receiver hold-off so the block backs up into its input
            if (ph == 0) hold_seq++;
            run_messages(80);
        end

        quiesce();
        if (sb.pending() != 0) sb.report_error("expected crc words left over");
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/crcbe_pkg.sv
rtl/crcbe_queue.sv
rtl/crcbe_front.sv
rtl/crcbe_back.sv
rtl/configurable_crc_byte_engine.sv
rtl/crcbe_checker.sv
tb/sv/tb_top.sv
